>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Assertions are compiled for simulation only and vanish under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define SAES_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define SAES_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SAES_ASSERT(label, clk, rst_n, prop, msg)
`define SAES_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> hw/rtl/saes_pkg.sv
// ----------------------------------------------------------------------------
// saes_pkg
// Types, tables and nibble functions of the simplified AES cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package saes_pkg;

  localparam int BLOCK_W = 16;
  localparam int KEY_W   = 16;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [7:0]         word_t;
  typedef logic [3:0]         nib_t;
  typedef nib_t               nib_tab_t [16];

  // Operation codes carried with each transaction.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Round constants of the key schedule.
  localparam word_t RCON_1 = 8'h80;
  localparam word_t RCON_2 = 8'h30;

  localparam nib_tab_t SBOX_FWD = '{
    4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
  };
  localparam nib_tab_t SBOX_INV = '{
    4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
  };
  // Products in GF(16) modulo x^4+x+1; a zero nibble gives zero.
  localparam nib_tab_t MUL4 = '{
    4'h0, 4'h4, 4'h8, 4'hC, 4'h3, 4'h7, 4'hB, 4'hF,
    4'h6, 4'h2, 4'hE, 4'hA, 4'h5, 4'h1, 4'hD, 4'h9
  };
  localparam nib_tab_t MUL2 = '{
    4'h0, 4'h2, 4'h4, 4'h6, 4'h8, 4'hA, 4'hC, 4'hE,
    4'h3, 4'h1, 4'h7, 4'h5, 4'hB, 4'h9, 4'hF, 4'hD
  };
  localparam nib_tab_t MUL9 = '{
    4'h0, 4'h9, 4'h1, 4'h8, 4'h2, 4'hB, 4'h3, 4'hA,
    4'h4, 4'hD, 4'h5, 4'hC, 4'h6, 4'hF, 4'h7, 4'hE
  };

  // The three round keys, travelling as one group.
  typedef struct packed {
    block_t rk0;
    block_t rk1;
    block_t rk2;
  } key_set_t;

  function automatic block_t sub_fwd(input block_t v);
    return {SBOX_FWD[v[15:12]], SBOX_FWD[v[11:8]], SBOX_FWD[v[7:4]], SBOX_FWD[v[3:0]]};
  endfunction

  function automatic block_t sub_inv(input block_t v);
    return {SBOX_INV[v[15:12]], SBOX_INV[v[11:8]], SBOX_INV[v[7:4]], SBOX_INV[v[3:0]]};
  endfunction

  // Swaps nibbles 1 and 3; the row shift is its own inverse.
  function automatic block_t swap_rows(input block_t v);
    return {v[15:12], v[3:0], v[7:4], v[11:8]};
  endfunction

  function automatic block_t mix_fwd(input block_t v);
    return {v[15:12] ^ MUL4[v[11:8]], v[11:8] ^ MUL4[v[15:12]],
            v[7:4] ^ MUL4[v[3:0]], v[3:0] ^ MUL4[v[7:4]]};
  endfunction

  function automatic block_t mix_inv(input block_t v);
    return {MUL9[v[15:12]] ^ MUL2[v[11:8]], MUL2[v[15:12]] ^ MUL9[v[11:8]],
            MUL9[v[7:4]] ^ MUL2[v[3:0]], MUL2[v[7:4]] ^ MUL9[v[3:0]]};
  endfunction

  // Rotates the two nibbles of a word and substitutes both.
  function automatic word_t sub_rot(input word_t w);
    return {SBOX_FWD[w[3:0]], SBOX_FWD[w[7:4]]};
  endfunction

  function automatic key_set_t expand_key(input logic [KEY_W-1:0] key);
    word_t w0, w1, w2, w3, w4, w5;
    key_set_t rk;
    w0 = key[15:8];
    w1 = key[7:0];
    w2 = w0 ^ RCON_1 ^ sub_rot(w1);
    w3 = w2 ^ w1;
    w4 = w2 ^ RCON_2 ^ sub_rot(w3);
    w5 = w4 ^ w3;
    rk.rk0 = {w0, w1};
    rk.rk1 = {w2, w3};
    rk.rk2 = {w4, w5};
    return rk;
  endfunction

endpackage

>>> hw/rtl/saes_key_sched.sv
// ----------------------------------------------------------------------------
// saes_key_sched
// Holds the cipher key as its three expanded round keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module saes_key_sched (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [saes_pkg::KEY_W-1:0] cfg_wr_data,
  output saes_pkg::key_set_t         key_set
);

  saes_pkg::key_set_t rk_r;
  saes_pkg::key_set_t rk_nxt;

  // The expansion is done on the write, so the datapath sees settled keys.
  always_comb begin
    rk_nxt = rk_r;
    if (cfg_wr_en) begin
      rk_nxt = saes_pkg::expand_key(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r <= saes_pkg::expand_key('0);
    end else begin
      rk_r <= rk_nxt;
    end
  end

  assign key_set = rk_r;

endmodule

>>> hw/rtl/saes_round_pipe.sv
// ----------------------------------------------------------------------------
// saes_round_pipe
// Three-stage cipher datapath with per-stage valid bits and stall handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module saes_round_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  saes_pkg::key_set_t key_set,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  saes_pkg::block_t   in_data_block,
  output logic               out_valid,
  input  logic               out_stall,
  output saes_pkg::block_t   out_result_block
);

  logic             v1_r, v2_r, v3_r;
  logic             v1_nxt, v2_nxt, v3_nxt;
  logic             op1_r, op2_r;
  saes_pkg::block_t d1_r, d2_r, d3_r;
  saes_pkg::block_t d1_nxt, d2_nxt, d3_nxt;
  saes_pkg::block_t s1_add;
  saes_pkg::block_t s2_add;
  logic             en1, en2, en3;

  // A stage loads when it is empty or its contents move on.
  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // Stage 1: first key addition, then substitution and row shift (in the
  // inverse order when decrypting).
  always_comb begin
    s1_add = in_data_block ^
             ((in_operation == saes_pkg::OP_DECRYPT) ? key_set.rk2 : key_set.rk0);
    if (in_operation == saes_pkg::OP_DECRYPT) begin
      d1_nxt = saes_pkg::sub_inv(saes_pkg::swap_rows(s1_add));
    end else begin
      d1_nxt = saes_pkg::swap_rows(saes_pkg::sub_fwd(s1_add));
    end
  end

  // Stage 2: column mix and the middle key addition.
  always_comb begin
    s2_add = d1_r ^ key_set.rk1;
    if (op1_r == saes_pkg::OP_DECRYPT) begin
      d2_nxt = saes_pkg::mix_inv(s2_add);
    end else begin
      d2_nxt = saes_pkg::mix_fwd(d1_r) ^ key_set.rk1;
    end
  end

  // Stage 3: last substitution and row shift, then the final key addition.
  always_comb begin
    if (op2_r == saes_pkg::OP_DECRYPT) begin
      d3_nxt = saes_pkg::sub_inv(saes_pkg::swap_rows(d2_r)) ^ key_set.rk0;
    end else begin
      d3_nxt = saes_pkg::swap_rows(saes_pkg::sub_fwd(d2_r)) ^ key_set.rk2;
    end
  end

  assign v1_nxt = en1 ? in_valid : v1_r;
  assign v2_nxt = en2 ? v1_r     : v2_r;
  assign v3_nxt = en3 ? v2_r     : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_r  <= d1_nxt;
      op1_r <= in_operation;
    end
    if (en2) begin
      d2_r  <= d2_nxt;
      op2_r <= op1_r;
    end
    if (en3) begin
      d3_r <= d3_nxt;
    end
  end

  assign out_valid        = v3_r;
  assign out_result_block = d3_r;

  // The input side only holds off when every stage is occupied.
  `SAES_ASSERT(a_stall_full, clk, rst_n, in_stall |-> (v1_r && v2_r && v3_r),
               "input stalled with an empty stage")
  // A transaction in stage 2 that cannot move must keep its data.
  `SAES_ASSERT(a_hold_s2, clk, rst_n, (v2_r && !en3) |=> (v2_r && $stable(d2_r)),
               "stage 2 lost or changed a held transaction")
  // The output only becomes valid from a transaction in stage 2.
  `SAES_ASSERT(a_out_source, clk, rst_n, $rose(v3_r) |-> $past(v2_r),
               "output became valid without a transaction behind it")
  // Stage 1 is never overwritten while it is full and blocked.
  `SAES_NEVER(a_no_overrun, clk, rst_n, in_valid && !in_stall && v1_r && !en2,
              "stage 1 overwritten while blocked")

endmodule

>>> hw/rtl/simplified_aes_cipher_unit.sv
// ----------------------------------------------------------------------------
// simplified_aes_cipher_unit
// Simplified AES on 16-bit blocks: encrypt or decrypt one block a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   The key is written through cfg_wr_en / cfg_wr_data; it is expanded into
//   three round keys at the write and applies to transactions that follow.
//   Write it only while no transaction is in flight.
//   Input transactions (in_operation, in_data_block) are accepted when
//   in_valid is high and in_stall is low; in_operation 0 encrypts, 1 decrypts.
//   Each one gives one result on out_result_block, accepted when out_valid
//   is high and out_stall is low.
//   Each block passes through the three register stages of table and XOR
//   logic before out_valid rises. Throughput is one transaction per cycle
//   while out_stall is low, set by the pipeline, which takes a new block
//   every cycle unless in_stall is high.
//   When the receiver stalls, the stages fill up and in_stall rises only once
//   all three hold a transaction; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) empties the pipeline and restores the
//   round keys of an all-zero key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simplified_aes_cipher_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [saes_pkg::KEY_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic [saes_pkg::BLOCK_W-1:0] in_data_block,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [saes_pkg::BLOCK_W-1:0] out_result_block
);

  saes_pkg::key_set_t key_set;

  saes_key_sched u_key_sched (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .key_set     (key_set)
  );

  saes_round_pipe u_round_pipe (
    .clk              (clk),
    .rst_n            (rst_n),
    .key_set          (key_set),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_data_block    (in_data_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block)
  );

endmodule
